>>> rtl/core/ser_pkg.sv
// ser_pkg: types and constants shared by the spectrum energy rebinner.
// No dependencies.
`default_nettype none
package ser_pkg;
  localparam int MAX_CHANNELS = 4096;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 48;
  localparam logic [CfgIdxW-1:0] REG_MEAS_OFFSET = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MEAS_GAIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MEAS_QUAD   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REF_OFFSET  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REF_GAIN    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REF_QUAD    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_REF_COUNT   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_COL_SCALE   = 3'd7;
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_REBIN = 1'b1;

  typedef struct packed {
    logic [0:0]  action;
    logic [11:0] ref_channel;
    logic [31:0] ref_count;
    logic [11:0] meas_channel;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_channel;
    logic [62:0] rebinned_value;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] offset;
    logic signed [31:0] gain;
    logic signed [31:0] quad;
  } cal_t;
endpackage
`default_nettype wire

>>> rtl/core/ser_stream_if.sv
// ser_stream_if: valid/ready channel carrying one payload.
// Depends on nothing; payload type given by parameter.
`default_nettype none
interface ser_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ser_divider.sv
// ser_divider: restoring divider, 128-bit dividend by 64-bit divisor,
// one quotient bit per cycle, low 64 quotient bits. Depends on nothing.
`default_nettype none
module ser_divider (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] num,
  input  wire logic [63:0]  den,
  output logic              done,
  output logic [63:0]       quot
);
  logic [127:0] n_r, n_nxt;
  logic [64:0]  rem_r, rem_nxt;
  logic [63:0]  den_r;
  logic [63:0]  q_r, q_nxt;
  logic [7:0]   cnt_r;
  logic         busy_r;
  logic [64:0]  sh;

  always_comb begin
    sh = {rem_r[63:0], n_r[127]};
    n_nxt = {n_r[126:0], 1'b0};
    if (sh >= {1'b0, den_r}) begin
      rem_nxt = sh - {1'b0, den_r};
      q_nxt = {q_r[62:0], 1'b1};
    end else begin
      rem_nxt = sh;
      q_nxt = {q_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 8'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 8'd1;
        if (cnt_r == 8'd127) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      n_r <= n_nxt;
      rem_r <= rem_nxt;
      q_r <= q_nxt;
    end
  end
  assign quot = q_r;
endmodule
`default_nettype wire

>>> rtl/core/spectrum_energy_rebinner.sv
// spectrum_energy_rebinner: top level; count memory, sequencer, energy walk,
// shared 32x32 multiplier and final scale.
// Depends on ser_pkg, ser_stream_if, ser_divider.
//
// channel | dir | payload
// in      | in  | action, ref_channel, ref_count, meas_channel
// out     | out | out_channel, rebinned_value, saturated
// cfg     | in  | cfg_we, cfg_index, cfg_data
//
// A rebin holds the block through the setup states, a read and an overlap test
// per valid reference channel, and for each channel with positive overlap a
// 4-step multiply and a 128-step serial divide; the result then waits for out ready.
// One request at a time; in ready only while idle.
// Reset is synchronous; the count memory is not cleared.
`default_nettype none
module spectrum_energy_rebinner (
  input  wire logic clk,
  input  wire logic rst_n,
  ser_stream_if.sink   in_s,
  ser_stream_if.source out_s,
  input  wire logic                          cfg_we,
  input  wire logic [ser_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [ser_pkg::CfgDataW-1:0]  cfg_data
);
  import ser_pkg::*;
  localparam int AW = $clog2(MAX_CHANNELS);
  localparam logic [3:0] S_IDLE = 4'd0, S_M0 = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
    S_RD = 4'd4, S_WAIT = 4'd5, S_MULT = 4'd6, S_CALC = 4'd7, S_DIV = 4'd8,
    S_SCALE = 4'd9, S_OUT = 4'd10;

  cal_t meas_r, ref_r;
  logic [12:0] cnt_cfg_r;
  logic [47:0] scale_r;
  logic [31:0] mem [MAX_CHANNELS];
  logic [31:0] rd_r;
  logic [3:0]  st_r;
  logic [12:0] r_r, n_lim;
  logic [11:0] mch_r;
  logic [23:0] msq_r;
  logic signed [63:0] mlin_r, mdq_r, mq_r;
  logic signed [63:0] rlin_r, rq_r, rdq_r;
  logic signed [63:0] ms_r, me_r, rs_r, re_r;
  logic [63:0] sum_r, w_r;
  logic [63:0] ma_r, mb_r;
  logic [127:0] acc_r;
  logic [1:0]  step_r;
  logic div_start, div_done;
  logic [63:0] div_q;
  logic signed [63:0] os, oe;
  logic signed [12:0] mch_s;
  logic signed [13:0] mch2_s;
  logic signed [44:0] m_lin;
  logic signed [45:0] m_dq;
  logic signed [56:0] m_q;
  logic signed [63:0] m_base, r_base, re_nxt;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  out_item_t res_r;
  logic ov_r;

  always_comb begin
    if (cnt_cfg_r > 13'(MAX_CHANNELS)) n_lim = 13'(MAX_CHANNELS);
    else n_lim = cnt_cfg_r;
    os = (ms_r > rs_r) ? ms_r : rs_r;
    oe = (me_r < re_r) ? me_r : re_r;
    mch_s = signed'({1'b0, mch_r});
    mch2_s = signed'({1'b0, mch_r, 1'b1});
    m_lin = meas_r.gain * mch_s;
    m_dq = meas_r.quad * mch2_s;
    m_q = meas_r.quad * signed'({1'b0, msq_r});
    m_base = 64'(meas_r.offset) <<< 16;
    r_base = 64'(ref_r.offset) <<< 16;
    // walk state holds channel r+1, so this is the upper edge of channel r
    re_nxt = r_base + (rlin_r <<< 8) + (rq_r >>> 8);
    pa = step_r[0] ? ma_r[63:32] : ma_r[31:0];
    pb = step_r[1] ? mb_r[63:32] : mb_r[31:0];
    pp = pa * pb;
    unique case (step_r)
      2'd0: pp_sh = {64'd0, pp};
      2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  assign in_s.ready = (st_r == S_IDLE);
  assign out_s.valid = (st_r == S_OUT);
  assign out_s.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_r <= '{32'sd0, 32'sd16777216, 32'sd0};
      ref_r <= '{32'sd0, 32'sd16777216, 32'sd0};
      cnt_cfg_r <= '0;
      scale_r <= 48'h1_0000_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEAS_OFFSET: meas_r.offset <= cfg_data[31:0];
        REG_MEAS_GAIN:   meas_r.gain <= cfg_data[31:0];
        REG_MEAS_QUAD:   meas_r.quad <= cfg_data[31:0];
        REG_REF_OFFSET:  ref_r.offset <= cfg_data[31:0];
        REG_REF_GAIN:    ref_r.gain <= cfg_data[31:0];
        REG_REF_QUAD:    ref_r.quad <= cfg_data[31:0];
        REG_REF_COUNT:   cnt_cfg_r <= cfg_data[12:0];
        REG_COL_SCALE:   scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready && in_s.data.action == ACT_LOAD &&
        32'(in_s.data.ref_channel) < 32'(MAX_CHANNELS))
      mem[in_s.data.ref_channel[AW-1:0]] <= in_s.data.ref_count;
    rd_r <= mem[r_r[AW-1:0]];
  end

  ser_divider u_div (.clk, .rst_n, .start(div_start), .num({acc_r[111:0], 16'd0}),
    .den(w_r), .done(div_done), .quot(div_q));

  assign div_start = (st_r == S_CALC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_s.valid && in_s.data.action == ACT_REBIN) begin
          mch_r <= in_s.data.meas_channel;
          st_r <= S_M0;
        end
        S_M0: begin
          msq_r <= mch_r * mch_r;
          mlin_r <= 64'(m_lin);
          mdq_r <= 64'(m_dq);
          st_r <= S_M1;
        end
        S_M1: begin
          mq_r <= 64'(m_q);
          st_r <= S_M2;
        end
        S_M2: begin
          ms_r <= m_base + (mlin_r <<< 8) + (mq_r >>> 8);
          me_r <= m_base + ((mlin_r + 64'(meas_r.gain)) <<< 8) + ((mq_r + mdq_r) >>> 8);
          rs_r <= r_base;
          rlin_r <= 64'(ref_r.gain);
          rq_r <= 64'(ref_r.quad);
          rdq_r <= (64'(ref_r.quad) <<< 1) + 64'(ref_r.quad);
          sum_r <= '0;
          r_r <= '0;
          st_r <= S_RD;
        end
        S_RD: if (r_r >= n_lim) begin
          ma_r <= sum_r;
          mb_r <= {16'd0, scale_r};
          acc_r <= '0;
          step_r <= '0;
          st_r <= S_SCALE;
        end else begin
          re_r <= re_nxt;
          rlin_r <= rlin_r + 64'(ref_r.gain);
          rq_r <= rq_r + rdq_r;
          rdq_r <= rdq_r + (64'(ref_r.quad) <<< 1);
          st_r <= S_WAIT;
        end
        S_WAIT: if (oe > os && re_r > rs_r) begin
          ma_r <= 64'(oe - os);
          mb_r <= {32'd0, rd_r};
          w_r <= 64'(re_r - rs_r);
          acc_r <= '0;
          step_r <= '0;
          st_r <= S_MULT;
        end else begin
          rs_r <= re_r;
          r_r <= r_r + 13'd1;
          st_r <= S_RD;
        end
        S_MULT: begin
          acc_r <= acc_r + pp_sh;
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) st_r <= S_CALC;
        end
        S_CALC: st_r <= S_DIV;
        S_DIV: if (div_done) begin
          sum_r <= sum_r + div_q;
          rs_r <= re_r;
          r_r <= r_r + 13'd1;
          st_r <= S_RD;
        end
        S_SCALE: begin
          acc_r <= acc_r + pp_sh;
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) st_r <= S_OUT;
        end
        S_OUT: if (out_s.ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ov_r = |acc_r[127:95];
    res_r.out_channel = mch_r;
    res_r.saturated = ov_r;
    res_r.rebinned_value = ov_r ? {63{1'b1}} : acc_r[94:32];
  end

`ifndef SYNTH
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> !in_s.ready) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && !out_s.ready |=> out_s.valid) else $error("result dropped");
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> st_r == S_DIV) else $error("divider start lost");
`endif
endmodule
`default_nettype wire

>>> dv/spectrum_energy_rebinner_checker.sv
// Checker for spectrum_energy_rebinner: tracks config writes and count loads,
// predicts each rebin result and compares it with the output channel.
// Depends on ser_pkg.
`default_nettype none
module spectrum_energy_rebinner_checker
  import ser_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  in_item_t                 in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 4096;

  logic signed [31:0] m_off, m_gain, m_quad, r_off, r_gain, r_quad;
  logic [12:0]        chan_count;
  logic [47:0]        col_scale;
  logic [31:0]        counts [TableDepth];
  out_item_t          rebin_q [$];

  function automatic logic signed [63:0] chan_energy(logic signed [31:0] off,
      logic signed [31:0] gain, logic signed [31:0] quad, int ch);
    logic signed [63:0] o, g, q, c;
    o = off;
    g = gain;
    q = quad;
    c = ch;
    return (o <<< 16) + ((g * c) <<< 8) + ((q * c * c) >>> 8);
  endfunction

  function automatic out_item_t rebin_result(logic [11:0] mch);
    logic signed [63:0] ms, me, rs, re, os, oe;
    logic [63:0]        sum, ov, wd;
    logic [127:0]       t, p;
    int                 n;
    out_item_t          res;
    ms = chan_energy(m_off, m_gain, m_quad, int'(mch));
    me = chan_energy(m_off, m_gain, m_quad, int'(mch) + 1);
    n = (chan_count > TableDepth) ? TableDepth : int'(chan_count);
    sum = '0;
    for (int r = 0; r < n; r++) begin
      rs = chan_energy(r_off, r_gain, r_quad, r);
      re = chan_energy(r_off, r_gain, r_quad, r + 1);
      os = (ms > rs) ? ms : rs;
      oe = (me < re) ? me : re;
      if (oe > os && re > rs) begin
        ov = oe - os;
        wd = re - rs;
        t = {64'b0, ov} * {96'b0, counts[r]};
        t = t << 16;
        t = t / {64'b0, wd};
        sum = sum + t[63:0];
      end
    end
    p = {64'b0, sum} * {80'b0, col_scale};
    res.out_channel = mch;
    if (|p[127:95]) begin
      res.rebinned_value = {63{1'b1}};
      res.saturated = 1'b1;
    end else begin
      res.rebinned_value = p[94:32];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      m_off = 0; m_gain = 32'sd16777216; m_quad = 0;
      r_off = 0; r_gain = 32'sd16777216; r_quad = 0;
      chan_count = '0;
      col_scale = 48'h1_0000_0000;
      rebin_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MEAS_OFFSET: m_off = cfg_data[31:0];
          REG_MEAS_GAIN:   m_gain = cfg_data[31:0];
          REG_MEAS_QUAD:   m_quad = cfg_data[31:0];
          REG_REF_OFFSET:  r_off = cfg_data[31:0];
          REG_REF_GAIN:    r_gain = cfg_data[31:0];
          REG_REF_QUAD:    r_quad = cfg_data[31:0];
          REG_REF_COUNT:   chan_count = cfg_data[12:0];
          REG_COL_SCALE:   col_scale = cfg_data[47:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (rebin_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result ch %0d value %h sat %b", out_data.out_channel,
                     out_data.rebinned_value, out_data.saturated);
        end else begin
          want = rebin_q.pop_front();
          if (want !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp ch %0d value %h sat %b, got ch %0d value %h sat %b",
                       want.out_channel, want.rebinned_value, want.saturated,
                       out_data.out_channel, out_data.rebinned_value, out_data.saturated);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.action == ACT_LOAD)
          counts[in_data.ref_channel] = in_data.ref_count;
        else
          rebin_q = {rebin_q, rebin_result(in_data.meas_channel)};
      end
    end
    pending = rebin_q.size();
  end
endmodule
`default_nettype wire

>>> dv/spectrum_energy_rebinner_tb.sv
// Top of the spectrum_energy_rebinner testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on ser_pkg, ser_stream_if and the checker.
`default_nettype none
module spectrum_energy_rebinner_tb;
  import ser_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int fail_count, pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  logic holding = 1'b0;
  event hold_ev;

  ser_stream_if #(.T(in_item_t))  in_if ();
  ser_stream_if #(.T(out_item_t)) out_if ();

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  spectrum_energy_rebinner dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_if.sink), .out_s(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  spectrum_energy_rebinner_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_data(in_if.data),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always begin
    @(hold_ev);
    holding = 1'b1;
    repeat (1500) @(posedge clk);
    holding = 1'b0;
  end

  always @(posedge clk) begin
    if (holding) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= item;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic load_count(int unsigned ch, logic [31:0] cnt);
    in_item_t item;
    item = '0;
    item.action = ACT_LOAD;
    item.ref_channel = ch[11:0];
    item.ref_count = cnt;
    item.meas_channel = 12'($urandom);
    send(item);
  endtask

  task automatic rebin(int unsigned ch);
    in_item_t item;
    item = '0;
    item.action = ACT_REBIN;
    item.ref_channel = 12'($urandom);
    item.ref_count = $urandom;
    item.meas_channel = ch[11:0];
    send(item);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CfgDataW-1:0] rand_gain();
    logic [31:0] g;
    g = $urandom_range(32'h0040_0000, 32'h0400_0000);
    if ($urandom_range(9) == 0) g = -g;
    return {16'b0, g};
  endfunction

  task automatic random_config(bit wild);
    if (wild) begin
      write_reg(REG_MEAS_OFFSET, {16'b0, $urandom});
      write_reg(REG_MEAS_GAIN, {16'b0, $urandom});
      write_reg(REG_MEAS_QUAD, {16'b0, $urandom});
      write_reg(REG_REF_OFFSET, {16'b0, $urandom});
      write_reg(REG_REF_GAIN, {16'b0, $urandom});
      write_reg(REG_REF_QUAD, {16'b0, $urandom});
      write_reg(REG_REF_COUNT, 48'd16);
      write_reg(REG_COL_SCALE, {16'($urandom), $urandom});
    end else begin
      write_reg(REG_MEAS_OFFSET, {16'b0, 32'($urandom_range(32'h20_0000)) - 32'h10_0000});
      write_reg(REG_MEAS_GAIN, rand_gain());
      write_reg(REG_MEAS_QUAD, {16'b0, 32'($urandom_range(32'h800_0000)) - 32'h400_0000});
      write_reg(REG_REF_OFFSET, {16'b0, 32'($urandom_range(32'h20_0000)) - 32'h10_0000});
      write_reg(REG_REF_GAIN, rand_gain());
      write_reg(REG_REF_QUAD, {16'b0, 32'($urandom_range(32'h800_0000)) - 32'h400_0000});
      write_reg(REG_REF_COUNT, 48'($urandom_range(16, 48)));
      write_reg(REG_COL_SCALE, {14'b0, 2'($urandom), $urandom});
    end
  endtask

  initial begin
    int n_ch;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero channel count after reset
    rebin(0);
    rebin(4095);
    drain();

    for (int i = 0; i < 64; i++)
      load_count(i, (i < 8) ? 32'hFFFF_FFFF : (i == 8) ? 32'h0 : $urandom);
    drain();

    // saturation: full counts under a wide measured channel, maximum scale
    write_reg(REG_REF_COUNT, 48'd8);
    write_reg(REG_MEAS_GAIN, 48'h0400_0000);
    write_reg(REG_COL_SCALE, 48'hFFFF_FFFF_FFFF);
    rebin(0);
    rebin(1);
    drain();
    write_reg(REG_COL_SCALE, 48'h0);
    rebin(0);
    drain();
    write_reg(REG_COL_SCALE, 48'h1_0000_0000);
    write_reg(REG_MEAS_GAIN, 48'h0100_0000);
    write_reg(REG_REF_GAIN, {16'b0, -32'sh0100_0000});
    rebin(0);
    drain();
    write_reg(REG_REF_GAIN, 48'h0100_0000);
    write_reg(REG_MEAS_GAIN, {16'b0, -32'sh0100_0000});
    rebin(3);
    drain();

    write_reg(REG_MEAS_OFFSET, 48'h8000_0000);
    write_reg(REG_REF_OFFSET, 48'h7FFF_FFFF);
    write_reg(REG_MEAS_QUAD, 48'h7FFF_FFFF);
    write_reg(REG_REF_QUAD, 48'h8000_0000);
    write_reg(REG_MEAS_GAIN, 48'h7FFF_FFFF);
    rebin(4095);
    rebin(0);
    drain();
    write_reg(REG_MEAS_OFFSET, 48'h7FFF_FFFF);
    write_reg(REG_REF_OFFSET, 48'h8000_0000);
    write_reg(REG_MEAS_QUAD, 48'h8000_0000);
    write_reg(REG_REF_QUAD, 48'h7FFF_FFFF);
    write_reg(REG_REF_GAIN, 48'h8000_0000);
    rebin(4095);
    rebin(7);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      random_config(ph == 5);
      n_ch = (ph == 5) ? 16 : int'(checker_i.chan_count);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      if (ph == 2) -> hold_ev;
      for (int k = 0; k < 170; k++) begin
        if ($urandom_range(99) < 55) begin
          load_count(($urandom_range(4) != 0) ? $urandom_range(n_ch - 1) : $urandom_range(4095),
                     $urandom);
        end else begin
          rebin(($urandom_range(6) != 0) ? $urandom_range(63) : $urandom_range(4095));
        end
      end
      drain();
    end

    stall_pct = 0;
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
